// ===== hdl/dsa_pkg.sv =====
package dsa_pkg;

	localparam int ADDR_W        = 64;
	localparam int SIZE_W        = 13;
	localparam int KIND_W        = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int HEAP_SLOTS_DEF = 1024;

	localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_XLATE   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE = 2'd2;

	localparam logic [SIZE_W-1:0] SLOT_SIZE_RST = 13'd32;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] address;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] cpu_address;
		logic [ADDR_W-1:0] gpu_address;
		logic              out_of_space;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REQ,
		ST_POP,
		ST_MUL,
		ST_ADD,
		ST_DIFF,
		ST_CHECK,
		ST_XLATE,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ===== hdl/dsa_ram.sv =====
module dsa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/dsa_div.sv =====
module dsa_div #(
	parameter int Q_W = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dsa_pkg::ADDR_W-1:0]  dividend,
	input  logic [dsa_pkg::SIZE_W-1:0]  divisor,
	output logic                        done,
	output logic [Q_W-1:0]              quotient
);

	localparam int CNT_W = $clog2(Q_W + 1);

	// dividend < divisor * 2^Q_W is required, so the high part fits below divisor
	logic [dsa_pkg::SIZE_W-1:0] rem_q;
	logic [dsa_pkg::SIZE_W-1:0] den_q;
	logic [Q_W-1:0]             low_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic [dsa_pkg::SIZE_W:0]   trial;
	logic                       qbit;

	assign trial = {rem_q, low_q[Q_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});
	assign done  = busy_q && (cnt_q == '0);
	assign quotient = low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(Q_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[Q_W+dsa_pkg::SIZE_W-1:Q_W];
			low_q <= dividend[Q_W-1:0];
			den_q <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= qbit ? dsa_pkg::SIZE_W'(trial - {1'b0, den_q})
			              : trial[dsa_pkg::SIZE_W-1:0];
			low_q <= (low_q << 1) | Q_W'(qbit);
		end
	end

endmodule

// ===== hdl/descriptor_slot_allocator.sv =====
// Descriptor slot allocator. A request beat pops the most recently freed slot index, or takes
// the next never-used one, and returns cpu_base + index * slot_size and the matching GPU
// address; when all HEAP_SLOTS indices are out it returns out_of_space with zero addresses.
// A free beat turns its address into an index and pushes it (out-of-range frees and frees
// onto a full stack are dropped, no result). A translate beat returns the address and
// gpu_base + (address - cpu_base). One item is worked at a time: a request steps through
// REQ, POP (only to pop the stack, for the free-stack read), MUL, ADD, OUT; a translate DIFF,
// XLATE, OUT; a free DIFF, CHECK and DIV, the bit-serial divider. The free stack sits
// in a single memory with no clearing pass; the output register lets the next item in while
// a result waits. Configuration writes are always accepted and must come while idle.
module descriptor_slot_allocator #(
	parameter int HEAP_SLOTS = dsa_pkg::HEAP_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  dsa_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dsa_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dsa_pkg::ADDR_W-1:0]    cfg_data
);

	localparam int IDX_W  = $clog2(HEAP_SLOTS);
	localparam int CNT_W  = $clog2(HEAP_SLOTS + 1);
	localparam int PROD_W = IDX_W + dsa_pkg::SIZE_W;
	localparam int LIM_W  = CNT_W + dsa_pkg::SIZE_W;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(HEAP_SLOTS);

	dsa_pkg::state_t state_q, state_d;

	logic [dsa_pkg::ADDR_W-1:0] cpu_base_q;
	logic [dsa_pkg::ADDR_W-1:0] gpu_base_q;
	logic [dsa_pkg::SIZE_W-1:0] slot_size_q;
	logic [dsa_pkg::SIZE_W-1:0] eff_size;

	logic [CNT_W-1:0] free_count_q;
	logic [CNT_W-1:0] next_fresh_q;

	logic [dsa_pkg::KIND_W-1:0] kind_q;
	logic [dsa_pkg::ADDR_W-1:0] addr_q;
	logic [dsa_pkg::ADDR_W-1:0] diff_q;
	logic [LIM_W-1:0]           limit_q;
	logic [IDX_W-1:0]           idx_q;
	logic [PROD_W-1:0]          off_q;
	dsa_pkg::out_item_t         res_q;

	logic               out_valid_q;
	dsa_pkg::out_item_t out_q;

	logic             ram_re;
	logic             ram_we;
	logic [IDX_W-1:0] ram_rdata;
	logic [IDX_W-1:0] ram_raddr;
	logic             div_start;
	logic             div_done;
	logic [IDX_W-1:0] div_quot;
	logic             load_out;
	logic             free_ok;
	logic             stack_empty;
	logic             fresh_left;

	assign eff_size    = (slot_size_q == '0) ? dsa_pkg::SIZE_W'(1) : slot_size_q;
	assign stack_empty = (free_count_q == '0);
	assign fresh_left  = (next_fresh_q < FULL);
	assign free_ok     = (diff_q < dsa_pkg::ADDR_W'(limit_q)) && (free_count_q < FULL);
	assign ram_raddr   = IDX_W'(free_count_q - 1'b1);

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_base_q  <= '0;
			gpu_base_q  <= '0;
			slot_size_q <= dsa_pkg::SLOT_SIZE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				dsa_pkg::REG_CPU_BASE:  cpu_base_q  <= cfg_data;
				dsa_pkg::REG_GPU_BASE:  gpu_base_q  <= cfg_data;
				dsa_pkg::REG_SLOT_SIZE: slot_size_q <= cfg_data[dsa_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dsa_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (in_data.kind)
						dsa_pkg::KIND_REQUEST: state_d = dsa_pkg::ST_REQ;
						dsa_pkg::KIND_FREE:    state_d = dsa_pkg::ST_DIFF;
						dsa_pkg::KIND_XLATE:   state_d = dsa_pkg::ST_DIFF;
						default:               state_d = dsa_pkg::ST_IDLE;
					endcase
				end
			end
			dsa_pkg::ST_REQ: begin
				if (!stack_empty) begin
					state_d = dsa_pkg::ST_POP;
				end else if (fresh_left) begin
					state_d = dsa_pkg::ST_MUL;
				end else begin
					state_d = dsa_pkg::ST_OUT;
				end
			end
			dsa_pkg::ST_POP:   state_d = dsa_pkg::ST_MUL;
			dsa_pkg::ST_MUL:   state_d = dsa_pkg::ST_ADD;
			dsa_pkg::ST_ADD:   state_d = dsa_pkg::ST_OUT;
			dsa_pkg::ST_DIFF: begin
				state_d = (kind_q == dsa_pkg::KIND_XLATE) ? dsa_pkg::ST_XLATE
				                                           : dsa_pkg::ST_CHECK;
			end
			dsa_pkg::ST_XLATE: state_d = dsa_pkg::ST_OUT;
			dsa_pkg::ST_CHECK: state_d = free_ok ? dsa_pkg::ST_DIV : dsa_pkg::ST_IDLE;
			dsa_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = dsa_pkg::ST_IDLE;
				end
			end
			dsa_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = dsa_pkg::ST_IDLE;
				end
			end
			default: state_d = dsa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			dsa_pkg::ST_IDLE:  in_ready  = 1'b1;
			dsa_pkg::ST_REQ:   ram_re    = !stack_empty;
			dsa_pkg::ST_CHECK: div_start = free_ok;
			dsa_pkg::ST_DIV:   ram_we    = div_done;
			dsa_pkg::ST_OUT:   load_out  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dsa_pkg::ST_IDLE;
			free_count_q <= '0;
			next_fresh_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dsa_pkg::ST_REQ) begin
				if (!stack_empty) begin
					free_count_q <= free_count_q - 1'b1;
				end else if (fresh_left) begin
					next_fresh_q <= next_fresh_q + 1'b1;
				end
			end
			if (ram_we) begin
				free_count_q <= free_count_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res_q;
		end
		case (state_q)
			dsa_pkg::ST_IDLE: begin
				kind_q <= in_data.kind;
				addr_q <= in_data.address;
			end
			dsa_pkg::ST_REQ: begin
				idx_q <= next_fresh_q[IDX_W-1:0];
				res_q <= '{cpu_address: '0, gpu_address: '0, out_of_space: 1'b1};
			end
			dsa_pkg::ST_POP: idx_q <= ram_rdata;
			dsa_pkg::ST_MUL: begin
				off_q <= {{dsa_pkg::SIZE_W{1'b0}}, idx_q} * {{IDX_W{1'b0}}, slot_size_q};
			end
			dsa_pkg::ST_ADD: begin
				res_q <= '{cpu_address:  cpu_base_q + dsa_pkg::ADDR_W'(off_q),
				           gpu_address:  gpu_base_q + dsa_pkg::ADDR_W'(off_q),
				           out_of_space: 1'b0};
			end
			dsa_pkg::ST_DIFF: begin
				diff_q  <= addr_q - cpu_base_q;
				limit_q <= LIM_W'(HEAP_SLOTS) * {{CNT_W{1'b0}}, eff_size};
			end
			dsa_pkg::ST_XLATE: begin
				res_q <= '{cpu_address:  addr_q,
				           gpu_address:  gpu_base_q + diff_q,
				           out_of_space: 1'b0};
			end
			default: ;
		endcase
	end

	dsa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (HEAP_SLOTS)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_count_q[IDX_W-1:0]),
		.wdata (div_quot),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dsa_div #(
		.Q_W (IDX_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff_q),
		.divisor  (eff_size),
		.done     (div_done),
		.quotient (div_quot)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= FULL && next_fresh_q <= FULL)
		else $error("stack count or fresh index past heap size");

	a_exhaust: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dsa_pkg::ST_REQ && stack_empty && !fresh_left)
		|=> (state_q == dsa_pkg::ST_OUT && res_q.out_of_space))
		else $error("exhausted request did not flag out_of_space");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == dsa_pkg::ST_DIV)
		else $error("divider finished outside a free");

	a_free_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dsa_pkg::ST_DIV |=> $stable(next_fresh_q))
		else $error("free moved the fresh index");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> free_count_q < FULL)
		else $error("push onto a full stack");

endmodule
